@@ design/ale_pkg.sv @@
`timescale 1ns / 1ps

package ale_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_LOCATE = 2'd3;

  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic [1:0]              mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        list_length;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_INS_SHIFT,
    ST_INS_FLUSH,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_DEL_FLUSH,
    ST_RD_WAIT,
    ST_FIND,
    ST_FIND_LAST,
    ST_DONE
  } state_t;

endpackage

@@ design/array_list_engine.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_t  (mode, position, value)
// rsp       out        rsp_valid/rsp_stall   rsp_t  (ok, value_out, found_position,
//                                                    list_length)
//
// One request at a time. Insert and delete shift the entries after the position, locate scans
// until the first match or the end of the list, and rejected requests go straight to the
// response; the engine returns to idle as rsp_valid rises, so the next request can be taken.
// The entry memory has a single read port: shift and scan walk one entry a cycle.
// Synchronous reset clears the length and control; entries need no clearing.
// A result waits in the output register during the next request, which holds until it drains.

module array_list_engine
  import ale_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Entry memory
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic signed [VAL_W-1:0] mem_wd;
  logic [AW-1:0]           mem_ra;
  logic signed [VAL_W-1:0] rdata;

  // Control and working registers
  state_t                  state, state_next;
  req_t                    cur;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           cursor, cursor_next;
  logic                    pend, pend_next;
  logic                    cap, cap_next;
  logic [AW-1:0]           pend_addr, pend_addr_next;
  logic                    res_ok, res_ok_next;
  logic signed [VAL_W-1:0] res_vout, res_vout_next;
  logic [CW-1:0]           res_fidx, res_fidx_next;

  // Range checks on the held request
  logic [WW-1:0] pos_ext, cnt_ext;
  logic [AW-1:0] pos_idx, last_idx;
  logic          in_range, ins_ok, ins_append, cnt_zero, hit;

  assign pos_ext    = WW'(cur.position);
  assign cnt_ext    = WW'(count);
  assign pos_idx    = AW'(pos_ext - WW'(1));
  assign last_idx   = AW'(cnt_ext - WW'(1));
  assign in_range   = (cur.position != '0) && (pos_ext <= cnt_ext);
  assign ins_ok     = (cur.position != '0) && (pos_ext <= cnt_ext + WW'(1)) &&
                      (count < CW'(CAPACITY));
  assign ins_append = (pos_ext == cnt_ext + WW'(1));
  assign cnt_zero   = (count == '0);
  assign hit        = (rdata == cur.value);

  assign req_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_START;
      end
      ST_START: begin
        case (cur.mode)
          MODE_INSERT: begin
            if (!ins_ok) state_next = ST_DONE;
            else if (ins_append) state_next = ST_INS_PUT;
            else state_next = ST_INS_SHIFT;
          end
          MODE_DELETE: state_next = in_range ? ST_DEL_SHIFT : ST_DONE;
          MODE_READ:   state_next = in_range ? ST_RD_WAIT : ST_DONE;
          MODE_LOCATE: state_next = cnt_zero ? ST_DONE : ST_FIND;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_INS_SHIFT: begin
        if (cursor == pos_idx) state_next = ST_INS_FLUSH;
      end
      ST_INS_FLUSH: state_next = ST_INS_PUT;
      ST_INS_PUT:   state_next = ST_DONE;
      ST_DEL_SHIFT: begin
        if (cursor == last_idx) state_next = ST_DEL_FLUSH;
      end
      ST_DEL_FLUSH: state_next = ST_DONE;
      ST_RD_WAIT:   state_next = ST_DONE;
      ST_FIND: begin
        if (pend && hit) state_next = ST_DONE;
        else if (cursor == last_idx) state_next = ST_FIND_LAST;
      end
      ST_FIND_LAST: state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and working register updates
  always_comb begin
    mem_we         = 1'b0;
    mem_wa         = pend_addr;
    mem_wd         = rdata;
    mem_ra         = cursor;
    count_next     = count;
    cursor_next    = cursor;
    pend_next      = pend;
    cap_next       = cap;
    pend_addr_next = pend_addr;
    res_ok_next    = res_ok;
    res_vout_next  = res_vout;
    res_fidx_next  = res_fidx;
    case (state)
      ST_START: begin
        // clear the result and pick the starting cursor
        res_ok_next   = 1'b0;
        res_vout_next = '0;
        res_fidx_next = '0;
        pend_next     = 1'b0;
        cap_next      = 1'b0;
        mem_ra        = pos_idx;
        case (cur.mode)
          MODE_INSERT: cursor_next = last_idx;
          MODE_DELETE: cursor_next = pos_idx;
          MODE_LOCATE: cursor_next = '0;
          default:     cursor_next = pos_idx;
        endcase
      end
      ST_INS_SHIFT: begin
        // read downward, write each entry one place higher once its read data returns
        mem_we         = pend;
        pend_next      = 1'b1;
        pend_addr_next = cursor + AW'(1);
        if (cursor != pos_idx) cursor_next = cursor - AW'(1);
      end
      ST_INS_FLUSH: begin
        mem_we = 1'b1;
      end
      ST_INS_PUT: begin
        mem_we      = 1'b1;
        mem_wa      = pos_idx;
        mem_wd      = cur.value;
        count_next  = count + CW'(1);
        res_ok_next = 1'b1;
      end
      ST_DEL_SHIFT: begin
        // first read is the removed entry, later reads move one place lower
        mem_we         = pend;
        if (cap) res_vout_next = rdata;
        cap_next       = (cursor == pos_idx);
        pend_next      = (cursor != pos_idx);
        pend_addr_next = cursor - AW'(1);
        if (cursor != last_idx) cursor_next = cursor + AW'(1);
      end
      ST_DEL_FLUSH: begin
        mem_we      = pend;
        if (cap) res_vout_next = rdata;
        count_next  = count - CW'(1);
        res_ok_next = 1'b1;
      end
      ST_RD_WAIT: begin
        res_vout_next = rdata;
        res_ok_next   = 1'b1;
      end
      ST_FIND: begin
        // compare the previous read while issuing the next one
        if (pend && hit) begin
          res_ok_next   = 1'b1;
          res_fidx_next = CW'(pend_addr) + CW'(1);
        end
        pend_next      = 1'b1;
        pend_addr_next = cursor;
        if (cursor != last_idx) cursor_next = cursor + AW'(1);
      end
      ST_FIND_LAST: begin
        if (hit) begin
          res_ok_next   = 1'b1;
          res_fidx_next = CW'(pend_addr) + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_DONE && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) cur <= req;
    cursor    <= cursor_next;
    pend      <= pend_next;
    cap       <= cap_next;
    pend_addr <= pend_addr_next;
    res_ok    <= res_ok_next;
    res_vout  <= res_vout_next;
    res_fidx  <= res_fidx_next;
    if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.ok             <= res_ok;
      rsp.value_out      <= res_vout;
      rsp.found_position <= POS_W'(res_fidx);
      rsp.list_length    <= POS_W'(count);
    end
  end

endmodule

@@ verif/array_list_engine_tb.sv @@
`timescale 1ns / 1ps

module array_list_engine_tb;
  import ale_pkg::*;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int          PHASE_ITEMS   = 60;
  localparam int          PHASE_COUNT   = 11;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // Mirror of the list contents; predicts one response per accepted request
  class list_scoreboard;
    logic signed [VAL_W-1:0] slots [CAPACITY];
    int                      length = 0;
    rsp_t                    expected_q [$];
    int unsigned             mismatches = 0;

    function void note_request(req_t r);
      rsp_t e;
      int   pos;
      int   k;
      e   = '0;
      pos = int'(r.position);
      case (r.mode)
        MODE_INSERT: begin
          if (pos >= 1 && pos <= length + 1 && length < CAPACITY) begin
            for (k = length; k >= pos; k--) slots[k] = slots[k-1];
            slots[pos-1] = r.value;
            length++;
            e.ok = 1'b1;
          end
        end
        MODE_DELETE: begin
          if (pos >= 1 && pos <= length) begin
            e.value_out = slots[pos-1];
            for (k = pos; k < length; k++) slots[k-1] = slots[k];
            length--;
            e.ok = 1'b1;
          end
        end
        MODE_READ: begin
          if (pos >= 1 && pos <= length) begin
            e.value_out = slots[pos-1];
            e.ok = 1'b1;
          end
        end
        default: begin
          // first match wins
          for (k = 0; k < length; k++) begin
            if (!e.ok && slots[k] == r.value) begin
              e.found_position = POS_W'(k + 1);
              e.ok = 1'b1;
            end
          end
        end
      endcase
      e.list_length = POS_W'(length);
      expected_q.push_back(e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      bit   bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("response with nothing pending: ok=%0d value_out=%0d pos=%0d len=%0d",
                   a.ok, a.value_out, a.found_position, a.list_length);
      end else begin
        e   = expected_q.pop_front();
        bad = (a.ok !== e.ok) || (a.value_out !== e.value_out) ||
              (a.found_position !== e.found_position) || (a.list_length !== e.list_length);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected ok=%0d value_out=%0d pos=%0d len=%0d, got ok=%0d value_out=%0d pos=%0d len=%0d",
                     e.ok, e.value_out, e.found_position, e.list_length,
                     a.ok, a.value_out, a.found_position, a.list_length);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  list_scoreboard sb;
  bit             steady       = 1'b0;
  bit             hold_request = 1'b0;
  int unsigned    cycles       = 0;

  array_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t make_req(logic [1:0] mode, int pos, logic signed [VAL_W-1:0] val);
    req_t r;
    r.mode     = mode;
    r.position = POS_W'(pos);
    r.value    = val;
    return r;
  endfunction

  // Mostly stored values for locate, small values for duplicates, some extremes
  function automatic logic signed [VAL_W-1:0] pick_value(bit for_locate);
    int                      roll;
    logic signed [VAL_W-1:0] v;
    roll = $urandom_range(0, 99);
    if (for_locate && sb.length > 0 && roll < 60)
      v = sb.slots[$urandom_range(0, sb.length - 1)];
    else if (roll < 70)
      v = $urandom;
    else if (roll < 85)
      v = VAL_W'($urandom_range(0, 7));
    else begin
      case ($urandom_range(0, 3))
        0:       v = {1'b1, {(VAL_W-1){1'b0}}};
        1:       v = {1'b0, {(VAL_W-1){1'b1}}};
        2:       v = '0;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  function automatic req_t make_random(mix_t mix);
    req_t r;
    int   roll;
    int   len;
    len  = sb.length;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  r.mode = roll < 70 ? MODE_INSERT : roll < 80 ? MODE_DELETE :
                          roll < 90 ? MODE_READ : MODE_LOCATE;
      MIX_DRAIN: r.mode = roll < 15 ? MODE_INSERT : roll < 70 ? MODE_DELETE :
                          roll < 85 ? MODE_READ : MODE_LOCATE;
      default:   r.mode = roll < 30 ? MODE_INSERT : roll < 55 ? MODE_DELETE :
                          roll < 78 ? MODE_READ : MODE_LOCATE;
    endcase
    // mostly in-range positions, some anywhere in the field
    if ($urandom_range(0, 99) < 15)
      r.position = POS_W'($urandom);
    else if (r.mode == MODE_INSERT)
      r.position = POS_W'($urandom_range(1, len + 1));
    else
      r.position = POS_W'($urandom_range(1, len > 0 ? len : 1));
    r.value = pick_value(r.mode == MODE_LOCATE);
    return r;
  endfunction

  // Offer one request, hold it until taken, then idle for a random gap, none when steady
  task automatic send_request(req_t r);
    int gap;
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    sb.note_request(r);
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stall at random before each response unless steady; hold off for a long stretch when asked
  task automatic collect_responses();
    int wait_cycles;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = steady ? 0 : $urandom_range(0, 3);
      if (wait_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (rsp_valid !== 1'b1) @(posedge clk);
      sb.check_response(rsp);
    end
  endtask

  task automatic run_directed();
    // empty list: every access misses
    send_request(make_req(MODE_READ,   1, 0));
    send_request(make_req(MODE_DELETE, 1, 0));
    send_request(make_req(MODE_LOCATE, 0, 0));
    // insert at position zero and past the end
    send_request(make_req(MODE_INSERT, 0, 11));
    send_request(make_req(MODE_INSERT, 2, 12));
    // extremes, insert at head, append a duplicate
    send_request(make_req(MODE_INSERT, 1, {1'b1, {(VAL_W-1){1'b0}}}));
    send_request(make_req(MODE_INSERT, 2, {1'b0, {(VAL_W-1){1'b1}}}));
    send_request(make_req(MODE_INSERT, 1, 5));
    send_request(make_req(MODE_INSERT, 4, 5));
    send_request(make_req(MODE_INSERT, 31, 9));
    // locate hit on duplicate, hit at extreme, miss
    send_request(make_req(MODE_LOCATE, 0, 5));
    send_request(make_req(MODE_LOCATE, 31, {1'b0, {(VAL_W-1){1'b1}}}));
    send_request(make_req(MODE_LOCATE, 0, 1234));
    // reads in and out of range
    send_request(make_req(MODE_READ, 0, 0));
    send_request(make_req(MODE_READ, 4, 0));
    send_request(make_req(MODE_READ, 5, 0));
    send_request(make_req(MODE_READ, 31, -1));
    // deletes out of range, at head, at tail
    send_request(make_req(MODE_DELETE, 31, 0));
    send_request(make_req(MODE_DELETE, 0, 0));
    send_request(make_req(MODE_DELETE, 1, 0));
    send_request(make_req(MODE_DELETE, 3, 0));
    send_request(make_req(MODE_READ,   2, 0));
  endtask

  task automatic run_random();
    mix_t mix;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      mix    = mix_t'(p % 3);
      steady = (p % 4 == 3);
      // back up the block with a long response hold-off
      if (p == 4) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(make_random(mix));
    end
    steady = 1'b0;
  endtask

  // Abort a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[array_list_engine] ERROR");
    $finish;
  end

  initial begin
    sb = new;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      collect_responses();
    join_none
    run_directed();
    run_random();
    req_valid <= 1'b0;
    // drain outstanding responses, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[array_list_engine] OK");
    else
      $display("[array_list_engine] ERROR");
    $finish;
  end

endmodule
